// File: rtl/trimmed_mean_encoder_angle_assert.svh
// Assertion macros used by the trimmed-mean encoder angle RTL.
`ifndef TRIMMED_MEAN_ENCODER_ANGLE_ASSERT_SVH
`define TRIMMED_MEAN_ENCODER_ANGLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TMEA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TMEA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/tmea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tmea_pkg;

   localparam int WINDOW_LEN = 40;
   localparam int TRIM_COUNT = 20;
   localparam int TRIM_LO    = (WINDOW_LEN - TRIM_COUNT) / 2;
   localparam int IDX_W      = $clog2(WINDOW_LEN);
   localparam int SUM_STEPS  = 4;
   localparam int SUM_LANES  = TRIM_COUNT / SUM_STEPS;
   localparam int STEP_W     = $clog2(SUM_STEPS);

   localparam int CODE_W   = 19;
   localparam int SUM_W    = 23;
   localparam int ANGLE_W  = 26;
   localparam int DIFF_W   = 27;
   localparam int OFFSET_W = 9;
   localparam int DEG_FRAC = 17;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   typedef logic [CODE_W-1:0] code_type;

   localparam code_type CODE_LIMIT = code_type'(262144);
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(184);
   localparam logic [OFFSET_W-1:0] OFFSET_MAX   = OFFSET_W'(360);
   localparam logic signed [DIFF_W-1:0] DEG_180 = DIFF_W'(180 * (1 << DEG_FRAC));
   localparam logic signed [DIFF_W-1:0] DEG_360 = DIFF_W'(360 * (1 << DEG_FRAC));
   localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(TRIM_COUNT * 262144);

   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_OFFSET = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSE     = 1'b1;

   // Comparison results a cell shows to its neighbors.
   typedef struct packed {
      logic lt_old;   // value below the code leaving the window
      logic le_new;   // value not above the code entering the window
   } cell_flags_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIFF,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

// File: rtl/tmea_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module tmea_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    upd,
   input  wire logic                    ins_high,
   input  wire tmea_pkg::code_type      new_code,
   input  wire tmea_pkg::code_type      old_code,
   input  wire tmea_pkg::code_type      left_val,
   input  wire tmea_pkg::cell_flags_type left_flags,
   input  wire tmea_pkg::code_type      right_val,
   input  wire tmea_pkg::cell_flags_type right_flags,
   output tmea_pkg::code_type           val,
   output tmea_pkg::cell_flags_type     flags
);
   import tmea_pkg::*;

   code_type val_ff;
   code_type val_in;

   assign val          = val_ff;
   assign flags.lt_old = val_ff < old_code;
   assign flags.le_new = val_ff <= new_code;

   always_comb begin
      val_in = val_ff;
      if (upd) begin
         if (ins_high) begin
            // Entries between the removed and inserted slot move down one place.
            if (flags.lt_old) begin
               val_in = val_ff;
            end else if (right_flags.le_new) begin
               val_in = right_val;
            end else if (flags.le_new) begin
               val_in = new_code;
            end
         end else begin
            // Entries between the inserted and removed slot move up one place.
            if (!left_flags.lt_old) begin
               val_in = val_ff;
            end else if (!left_flags.le_new) begin
               val_in = left_val;
            end else if (!flags.le_new) begin
               val_in = new_code;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else begin
         val_ff <= val_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/tmea_chain.sv
`timescale 1ns / 1ps
`default_nettype none
module tmea_chain (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               upd,
   input  wire tmea_pkg::code_type new_code,
   output tmea_pkg::code_type      sorted_vals [tmea_pkg::WINDOW_LEN]
);
   import tmea_pkg::*;

   code_type       age_ff [WINDOW_LEN];
   code_type       cell_val [WINDOW_LEN];
   cell_flags_type cell_flg [WINDOW_LEN];
   code_type       left_v [WINDOW_LEN];
   code_type       right_v [WINDOW_LEN];
   cell_flags_type left_f [WINDOW_LEN];
   cell_flags_type right_f [WINDOW_LEN];
   code_type       old_code;
   logic           ins_high;

   // The oldest age entry is the value that leaves the sorted row.
   assign old_code = age_ff[WINDOW_LEN-1];
   assign ins_high = new_code >= old_code;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            age_ff[i] <= '0;
         end
      end else if (upd) begin
         age_ff[0] <= new_code;
         for (int i = 1; i < WINDOW_LEN; i++) begin
            age_ff[i] <= age_ff[i-1];
         end
      end
   end

   for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_v[i] = '0;
         assign left_f[i] = '{lt_old: 1'b1, le_new: 1'b1};
      end else begin : g_mid_l
         assign left_v[i] = cell_val[i-1];
         assign left_f[i] = cell_flg[i-1];
      end
      if (i == WINDOW_LEN - 1) begin : g_last
         assign right_v[i] = '0;
         assign right_f[i] = '{lt_old: 1'b0, le_new: 1'b0};
      end else begin : g_mid_r
         assign right_v[i] = cell_val[i+1];
         assign right_f[i] = cell_flg[i+1];
      end

      tmea_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .upd         (upd),
         .ins_high    (ins_high),
         .new_code    (new_code),
         .old_code    (old_code),
         .left_val    (left_v[i]),
         .left_flags  (left_f[i]),
         .right_val   (right_v[i]),
         .right_flags (right_f[i]),
         .val         (cell_val[i]),
         .flags       (cell_flg[i])
      );

      assign sorted_vals[i] = cell_val[i];
   end

endmodule
`default_nettype wire

// File: rtl/trimmed_mean_encoder_angle.sv
`timescale 1ns / 1ps
`default_nettype none
// Trimmed-mean angle filter for an absolute encoder. Each req transaction carries
// one raw code; codes up to 262144 enter a 40-entry age window, larger ones are
// dropped (rsp_sample_accepted = 0) and the window is kept. The window is also held
// in ascending order by a row of 40 compare cells that removes the oldest code and
// inserts the new one in the same cycle. The 20 middle ranks are summed, scaled by
// 9 to units of 2^-17 degree, the zero offset is subtracted (offsets above 360 act
// as 360), and the result is wrapped to +/-180 degrees and optionally negated.
// An item goes from acceptance to a loaded result in steps: the cell row updates on
// the accepting edge, the summing state builds the trimmed sum (five ranks added per
// cycle into one accumulator), the difference state registers the offset subtract,
// the output state loads the wrap into the output register. The input is stalled
// from acceptance until the result is loaded, so no item is taken before the last
// is through; items also wait while a stalled result holds the output register. A
// new item is taken while a finished result waits in the output register. The window
// resets to all zeros; csr writes are expected only while no item is in flight.
module trimmed_mean_encoder_angle (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [tmea_pkg::CODE_W-1:0]           req_raw_code,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [tmea_pkg::ANGLE_W-1:0]        rsp_wrapped_angle,
   output logic [tmea_pkg::SUM_W-1:0]                 rsp_trimmed_sum,
   output logic                                       rsp_sample_accepted,
   input  wire logic                                  csr_we,
   input  wire logic [tmea_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [tmea_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import tmea_pkg::*;

`include "trimmed_mean_encoder_angle_assert.svh"

   state_type state_ff;
   state_type state_in;

   logic [STEP_W-1:0]   step_ff;
   logic [STEP_W-1:0]   step_in;
   logic [SUM_W-1:0]    acc_ff;
   logic [SUM_W-1:0]    acc_in;
   logic                accepted_ff;
   logic                accepted_in;
   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [DIFF_W-1:0] diff_in;
   logic [OFFSET_W-1:0] zero_offset_ff;
   logic [OFFSET_W-1:0] zero_offset_in;
   logic                reverse_ff;
   logic                reverse_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic signed [ANGLE_W-1:0] angle_ff;
   logic signed [ANGLE_W-1:0] angle_in;
   logic [SUM_W-1:0]    sum_out_ff;
   logic                acc_out_ff;

   logic     accept;
   logic     code_ok;
   logic     upd;
   logic     sum_en;
   logic     diff_en;
   logic     load_out;
   logic     out_free;
   logic     last_step;
   logic [SUM_W-1:0] lane_sum;
   logic [DIFF_W-1:0] meas;
   logic [DIFF_W-1:0] off_scaled;
   logic [OFFSET_W-1:0] off_sat;
   logic signed [DIFF_W-1:0] wrapped;
   code_type sorted_vals [WINDOW_LEN];

   assign accept    = req_valid && !req_stall;
   assign code_ok   = req_raw_code <= CODE_LIMIT;
   assign upd       = accept && code_ok;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_step = step_ff == STEP_W'(SUM_STEPS - 1);

   tmea_chain u_chain (
      .clock       (clock),
      .reset       (reset),
      .upd         (upd),
      .new_code    (req_raw_code),
      .sorted_vals (sorted_vals)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_SUM;
         ST_SUM:  if (last_step) state_in = ST_DIFF;
         ST_DIFF: state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req_stall = 1'b1;
      sum_en    = 1'b0;
      diff_en   = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_SUM:  sum_en    = 1'b1;
         ST_DIFF: diff_en   = 1'b1;
         ST_OUT:  load_out  = out_free;
         default: req_stall = 1'b1;
      endcase
   end

   // Five ranks per step, picked by the step counter.
   always_comb begin
      logic [IDX_W-1:0] idx;
      lane_sum = '0;
      for (int j = 0; j < SUM_LANES; j++) begin
         idx = IDX_W'(TRIM_LO + int'(step_ff) * SUM_LANES + j);
         lane_sum = lane_sum + SUM_W'(sorted_vals[idx]);
      end
   end

   always_comb begin
      step_in     = step_ff;
      acc_in      = acc_ff;
      accepted_in = accepted_ff;
      if (accept) begin
         step_in     = '0;
         acc_in      = '0;
         accepted_in = code_ok;
      end else if (sum_en) begin
         step_in = step_ff + STEP_W'(1);
         acc_in  = acc_ff + lane_sum;
      end
   end

   assign off_sat    = (zero_offset_ff > OFFSET_MAX) ? OFFSET_MAX : zero_offset_ff;
   assign meas       = (DIFF_W'(acc_ff) << 3) + DIFF_W'(acc_ff);
   assign off_scaled = DIFF_W'(off_sat) << DEG_FRAC;
   assign diff_in    = signed'(meas - off_scaled);

   always_comb begin
      if (diff_ff > DEG_180) begin
         wrapped = diff_ff - DEG_360;
      end else if (diff_ff < -DEG_180) begin
         wrapped = diff_ff + DEG_360;
      end else begin
         wrapped = diff_ff;
      end
      angle_in = reverse_ff ? ANGLE_W'(-wrapped) : ANGLE_W'(wrapped);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      zero_offset_in = zero_offset_ff;
      reverse_in     = reverse_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ZERO_OFFSET: zero_offset_in = csr_wdata[OFFSET_W-1:0];
            CSR_REVERSE:     reverse_in     = csr_wdata[0];
            default:         zero_offset_in = zero_offset_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         zero_offset_ff <= OFFSET_RESET;
         reverse_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         rsp_valid_ff   <= rsp_valid_in;
         zero_offset_ff <= zero_offset_in;
         reverse_ff     <= reverse_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      accepted_ff <= accepted_in;
      if (diff_en) begin
         diff_ff <= diff_in;
      end
      if (load_out) begin
         angle_ff   <= angle_in;
         sum_out_ff <= acc_ff;
         acc_out_ff <= accepted_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_wrapped_angle   = angle_ff;
   assign rsp_trimmed_sum     = sum_out_ff;
   assign rsp_sample_accepted = acc_out_ff;

   `TMEA_ASSERT_NEXT(a_accept_starts_sum, clock, reset, accept, (state_ff == ST_SUM) && (step_ff == '0), "accepted transaction did not start the trimmed sum")
   `TMEA_ASSERT_IMPLY(a_sum_range, clock, reset, rsp_valid_ff, sum_out_ff <= SUM_MAX, "trimmed sum above its largest possible value")
   `TMEA_ASSERT_IMPLY(a_angle_range, clock, reset, rsp_valid_ff, (SUM_W + 4)'(signed'(angle_ff)) <= DEG_180 && (SUM_W + 4)'(signed'(angle_ff)) >= -DEG_180, "joint angle outside +/-180 degrees")
   `TMEA_ASSERT_IMPLY(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_OUT), "response raised outside the output state")

   for (genvar i = 0; i < WINDOW_LEN - 1; i++) begin : g_order_chk
      `TMEA_ASSERT_IMPLY(a_sorted, clock, reset, 1'b1, sorted_vals[i] <= sorted_vals[i+1], "cell row out of ascending order")
   end

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
   import tmea_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 1750;
   localparam int LONG_HOLD      = 300;
   localparam code_type CODE_TOP = '1;

   typedef struct {
      logic signed [ANGLE_W-1:0] angle;
      logic [SUM_W-1:0]          sum;
      logic                      accepted;
   } angle_result_type;

   typedef enum int {
      STYLE_NOISE,
      STYLE_CLUSTER,
      STYLE_LEVEL,
      STYLE_EDGES
   } code_style_type;

   class angle_tracker;
      code_type                window[WINDOW_LEN];
      logic [OFFSET_W-1:0]     zero_offset;
      logic                    reverse;
      angle_result_type        expected_angles[$];
      int                      errors;
      int                      checked;

      function new();
         foreach (window[i]) window[i] = '0;
         zero_offset = OFFSET_RESET;
         reverse = 1'b0;
         errors = 0;
         checked = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_ZERO_OFFSET) begin
            zero_offset = data[OFFSET_W-1:0];
         end else if (idx == CSR_REVERSE) begin
            reverse = data[0];
         end
      endfunction

      // Push an accepted code into the age window and predict the angle for this transaction.
      function void note_code(code_type code);
         code_type         ranked[$];
         angle_result_type r;
         longint           off;
         longint           diff;
         int               i;
         r.accepted = (code <= CODE_LIMIT);
         if (r.accepted) begin
            for (i = WINDOW_LEN - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = code;
         end
         foreach (window[k]) ranked.push_back(window[k]);
         ranked.sort();
         r.sum = '0;
         for (i = TRIM_LO; i < TRIM_LO + TRIM_COUNT; i++) r.sum += SUM_W'(ranked[i]);
         off = (zero_offset > OFFSET_MAX) ? OFFSET_MAX : zero_offset;
         diff = longint'(r.sum) * 9 - off * (longint'(1) << DEG_FRAC);
         // exact +/-180 stays as is
         if (diff > longint'(DEG_180)) begin
            diff -= longint'(DEG_360);
         end else if (diff < -longint'(DEG_180)) begin
            diff += longint'(DEG_360);
         end
         if (reverse) diff = -diff;
         r.angle = diff[ANGLE_W-1:0];
         expected_angles.push_back(r);
      endfunction

      function void check_angle(logic signed [ANGLE_W-1:0] angle, logic [SUM_W-1:0] sum,
                                logic accepted);
         angle_result_type want;
         checked++;
         if (expected_angles.size() == 0) begin
            $error("result with no pending transaction: wrapped_angle %0d trimmed_sum %0d",
                   angle, sum);
            errors++;
            return;
         end
         want = expected_angles.pop_front();
         if (angle !== want.angle) begin
            $error("wrapped_angle: expected %0d, got %0d", want.angle, angle);
            errors++;
         end
         if (sum !== want.sum) begin
            $error("trimmed_sum: expected %0d, got %0d", want.sum, sum);
            errors++;
         end
         if (accepted !== want.accepted) begin
            $error("sample_accepted: expected %0d, got %0d", want.accepted, accepted);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   code_type                  req_raw_code = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [ANGLE_W-1:0] rsp_wrapped_angle;
   logic [SUM_W-1:0]          rsp_trimmed_sum;
   logic                      rsp_sample_accepted;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   angle_tracker tracker = new();
   int           quiet_cycles = 0;

   trimmed_mean_encoder_angle DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_raw_code        (req_raw_code),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_wrapped_angle   (rsp_wrapped_angle),
      .rsp_trimmed_sum     (rsp_trimmed_sum),
      .rsp_sample_accepted (rsp_sample_accepted),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) tracker.note_code(req_raw_code);
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_angle(rsp_wrapped_angle, rsp_trimmed_sum, rsp_sample_accepted);
      end
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Result side: free runs, random stalls, long stalls, and one long hold-off.
   initial begin : result_sink
      int n;
      bit jitter;
      bit level;
      bit held;
      int pick;
      held = 1'b0;
      forever begin
         pick = $urandom_range(0, 9);
         if (!held && tracker.checked >= 400) begin
            held = 1'b1;
            jitter = 1'b0;
            level = 1'b1;
            n = LONG_HOLD;
         end else if (pick < 5) begin
            jitter = 1'b0;
            level = 1'b0;
            n = $urandom_range(1, 40);
         end else if (pick < 9) begin
            jitter = 1'b1;
            level = 1'b0;
            n = $urandom_range(1, 40);
         end else begin
            jitter = 1'b0;
            level = 1'b1;
            n = $urandom_range(20, 80);
         end
         repeat (n) begin
            @(posedge clock);
            rsp_stall <= jitter ? ($urandom_range(0, 2) == 0) : level;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic code_type next_code(code_style_type style, code_type base, int spread);
      int v;
      case (style)
         STYLE_NOISE: begin
            return code_type'($urandom);
         end
         STYLE_CLUSTER, STYLE_LEVEL: begin
            if ($urandom_range(0, 19) == 0) begin
               return code_type'($urandom_range(CODE_LIMIT + 1, CODE_TOP));
            end
            v = int'(base) + int'($urandom_range(0, spread)) - spread / 2;
            if (v < 0) v = 0;
            if (v > int'(CODE_LIMIT)) v = int'(CODE_LIMIT);
            return code_type'(v);
         end
         default: begin
            case ($urandom_range(0, 6))
               0: return '0;
               1: return code_type'(1);
               2: return code_type'(CODE_LIMIT - 1);
               3: return CODE_LIMIT;
               4: return code_type'(CODE_LIMIT + 1);
               5: return CODE_TOP;
               default: return code_type'($urandom);
            endcase
         end
      endcase
   endfunction

   // Hold the payload until accepted; valid stays high into the next transaction.
   task automatic send_code(code_type code, bit no_gaps);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_code <= code;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop offering and wait until every predicted angle has come back.
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_angles.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      tracker.write_reg(idx, data);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      int                    sent;
      int                    phase;
      int                    count;
      int                    spread;
      int                    pick;
      bit                    no_gaps;
      code_style_type        style;
      code_type              base;
      logic [CSR_DATA_W-1:0] offset_data;
      logic [CSR_DATA_W-1:0] reverse_data;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Field extremes and the accept/reject boundary at the reset settings.
      send_code('0, 1'b0);
      send_code(CODE_LIMIT, 1'b0);
      send_code(code_type'(CODE_LIMIT + 1), 1'b0);
      send_code(CODE_TOP, 1'b0);
      send_code(code_type'(1), 1'b1);
      send_code(code_type'(CODE_LIMIT - 1), 1'b1);
      send_code(code_type'(19'h2AAAA), 1'b0);
      send_code(code_type'(19'h55555), 1'b0);
      send_code(code_type'(131072), 1'b0);

      // Zero trimmed sum with offset 180 lands exactly on -180 degrees.
      quiesce();
      set_reg(CSR_ZERO_OFFSET, CSR_DATA_W'(180));
      send_code(CODE_TOP, 1'b0);
      send_code(code_type'(7), 1'b0);

      // Reverse sense with a saturated offset.
      quiesce();
      set_reg(CSR_REVERSE, CSR_DATA_W'(9'h1FF));
      set_reg(CSR_ZERO_OFFSET, CSR_DATA_W'(511));
      send_code(CODE_LIMIT, 1'b0);
      send_code(code_type'(200000), 1'b0);

      quiesce();
      set_reg(CSR_ZERO_OFFSET, '0);
      set_reg(CSR_REVERSE, CSR_DATA_W'(9'h1FE));
      send_code('0, 1'b0);
      send_code(CODE_TOP, 1'b0);

      quiesce();
      set_reg(CSR_ZERO_OFFSET, CSR_DATA_W'(360));
      send_code(CODE_LIMIT, 1'b0);
      send_code(code_type'(5), 1'b0);

      quiesce();
      set_reg(CSR_ZERO_OFFSET, CSR_DATA_W'(361));
      send_code(code_type'(100), 1'b0);

      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         quiesce();
         count = $urandom_range(70, 130);
         spread = 0;
         base = code_type'($urandom_range(0, CODE_LIMIT));
         if (phase == 0) begin
            // Full window at mid scale with no offset sits exactly on +180 degrees.
            offset_data = '0;
            reverse_data = '0;
            style = STYLE_LEVEL;
            base = code_type'(131072);
            count = 60;
         end else if (phase == 1) begin
            offset_data = CSR_DATA_W'(360);
            reverse_data = CSR_DATA_W'($urandom) | CSR_DATA_W'(1);
            style = STYLE_NOISE;
         end else begin
            case ($urandom_range(0, 5))
               0: offset_data = '0;
               1: offset_data = CSR_DATA_W'(360);
               2: offset_data = CSR_DATA_W'(511);
               3: offset_data = CSR_DATA_W'($urandom_range(361, 511));
               default: offset_data = CSR_DATA_W'($urandom_range(0, 360));
            endcase
            reverse_data = CSR_DATA_W'($urandom);
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
               style = STYLE_CLUSTER;
               spread = 1 << $urandom_range(0, 17);
            end else if (pick < 7) begin
               style = STYLE_NOISE;
            end else if (pick < 8) begin
               style = STYLE_LEVEL;
            end else begin
               style = STYLE_EDGES;
            end
         end
         set_reg(CSR_ZERO_OFFSET, offset_data);
         set_reg(CSR_REVERSE, reverse_data);
         no_gaps = ($urandom_range(0, 3) == 0);
         repeat (count) begin
            send_code(next_code(style, base, spread), no_gaps);
            sent++;
         end
         phase++;
      end

      quiesce();
      if (tracker.errors == 0 && tracker.expected_angles.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
